// File: design/rmq_pkg.sv
`default_nettype none

package rmq_pkg;

   // field width of every matrix entry and quaternion component
   localparam int FIELD_W = 16;

   // default fraction bits of the fixed point format
   localparam int FRAC_BITS_DEF = 14;

   typedef struct packed {
      logic signed [FIELD_W-1:0] rot_r0c0;
      logic signed [FIELD_W-1:0] rot_r0c1;
      logic signed [FIELD_W-1:0] rot_r0c2;
      logic signed [FIELD_W-1:0] rot_r1c0;
      logic signed [FIELD_W-1:0] rot_r1c1;
      logic signed [FIELD_W-1:0] rot_r1c2;
      logic signed [FIELD_W-1:0] rot_r2c0;
      logic signed [FIELD_W-1:0] rot_r2c1;
      logic signed [FIELD_W-1:0] rot_r2c2;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] quat_w;
      logic signed [FIELD_W-1:0] quat_x;
      logic signed [FIELD_W-1:0] quat_y;
      logic signed [FIELD_W-1:0] quat_z;
   } rsp_type;

   // quaternion component order
   localparam int COMP_W = 0;
   localparam int COMP_X = 1;
   localparam int COMP_Y = 2;
   localparam int COMP_Z = 3;
   localparam int NCOMP  = 4;

endpackage

`default_nettype wire

// File: design/rotation_matrix_to_quaternion.sv
`default_nettype none

// channel   ports                          direction  transfer when
// request   req_valid req_stall req_data   in         req_valid && !req_stall
// response  rsp_valid rsp_stall rsp_data   out        rsp_valid && !rsp_stall
//
// one matrix enters per cycle unless stalled; the pipeline stages are
// trace stage, sum stage, 2*FRAC_BITS + 3 divider stages for the integer bit
// and each fraction bit, FRAC_BITS + 2 square root stages, output register
// synchronous reset clears only the valid bits of the pipeline
// a stalled response freezes the whole pipeline; nothing is lost or repeated

module rotation_matrix_to_quaternion #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  rmq_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output rmq_pkg::rsp_type    rsp_data
);

   localparam int FW  = rmq_pkg::FIELD_W;
   localparam int NC  = rmq_pkg::NCOMP;
   localparam int F   = FRAC_BITS;
   localparam int BW  = (F > FW + 1) ? F : FW + 1;
   localparam int TW  = BW + 3;
   localparam int VW  = BW + 2;
   localparam int DW  = VW + 2;
   localparam int P   = 2 * F + 2;
   localparam int QW  = P + 1;
   localparam int R   = F + 2;
   localparam int SW  = R + 2;
   localparam int LIM = (F < FW - 1) ? (1 << F) : ((1 << (FW - 1)) - 1);
   localparam logic signed [TW-1:0] ONE = TW'(1) << F;

   logic adv;

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // ---------------- stage a: clamped trace terms and sign tests ----------------
   logic signed [TW-1:0] m00, m11, m22;
   logic signed [TW-1:0] t_in [NC];
   logic [VW-1:0]        a_v_in [NC];
   logic [5:0]           a_neg_in;
   logic signed [FW:0]   d21m, d02m, d10m, s10p, s02p, s21p;

   logic                 a_valid_ff;
   logic [VW-1:0]        a_v_ff [NC];
   logic [5:0]           a_neg_ff;

   always_comb begin
      m00 = TW'(req_data.rot_r0c0);
      m11 = TW'(req_data.rot_r1c1);
      m22 = TW'(req_data.rot_r2c2);
      t_in[0] =  m00 + m11 + m22 + ONE;
      t_in[1] =  m00 - m11 - m22 + ONE;
      t_in[2] = -m00 + m11 - m22 + ONE;
      t_in[3] = -m00 - m11 + m22 + ONE;
      for (int k = 0; k < NC; k++) begin
         a_v_in[k] = (t_in[k] > 0) ? t_in[k][VW-1:0] : '0;
      end
      d21m = (FW+1)'(req_data.rot_r2c1) - (FW+1)'(req_data.rot_r1c2);
      d02m = (FW+1)'(req_data.rot_r0c2) - (FW+1)'(req_data.rot_r2c0);
      d10m = (FW+1)'(req_data.rot_r1c0) - (FW+1)'(req_data.rot_r0c1);
      s10p = (FW+1)'(req_data.rot_r1c0) + (FW+1)'(req_data.rot_r0c1);
      s02p = (FW+1)'(req_data.rot_r0c2) + (FW+1)'(req_data.rot_r2c0);
      s21p = (FW+1)'(req_data.rot_r2c1) + (FW+1)'(req_data.rot_r1c2);
      a_neg_in = {s21p[FW], s02p[FW], s10p[FW], d10m[FW], d02m[FW], d21m[FW]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
      end
      if (adv) begin
         a_v_ff   <= a_v_in;
         a_neg_ff <= a_neg_in;
      end
   end

   // ---------------- stage b: norm sum, largest term, signs ----------------
   logic [DW-1:0] b_sum_in;
   logic [1:0]    big;
   logic [NC-1:0] b_neg_in;

   logic          b_valid_ff;
   logic [VW-1:0] b_v_ff [NC];
   logic [DW-1:0] b_sum_ff;
   logic [NC-1:0] b_neg_ff;

   always_comb begin
      b_sum_in = DW'(a_v_ff[0]) + DW'(a_v_ff[1]) + DW'(a_v_ff[2]) + DW'(a_v_ff[3]);
      big = 2'd0;
      if (a_v_ff[1] > a_v_ff[big]) big = 2'd1;
      if (a_v_ff[2] > a_v_ff[big]) big = 2'd2;
      if (a_v_ff[3] > a_v_ff[big]) big = 2'd3;
      b_neg_in = '0;
      case (big)
         2'd0: begin
            b_neg_in[rmq_pkg::COMP_X] = a_neg_ff[0];
            b_neg_in[rmq_pkg::COMP_Y] = a_neg_ff[1];
            b_neg_in[rmq_pkg::COMP_Z] = a_neg_ff[2];
         end
         2'd1: begin
            b_neg_in[rmq_pkg::COMP_W] = a_neg_ff[0];
            b_neg_in[rmq_pkg::COMP_Y] = a_neg_ff[3];
            b_neg_in[rmq_pkg::COMP_Z] = a_neg_ff[4];
         end
         2'd2: begin
            b_neg_in[rmq_pkg::COMP_W] = a_neg_ff[1];
            b_neg_in[rmq_pkg::COMP_X] = a_neg_ff[3];
            b_neg_in[rmq_pkg::COMP_Z] = a_neg_ff[5];
         end
         default: begin
            b_neg_in[rmq_pkg::COMP_W] = a_neg_ff[2];
            b_neg_in[rmq_pkg::COMP_X] = a_neg_ff[4];
            b_neg_in[rmq_pkg::COMP_Y] = a_neg_ff[5];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
      if (adv) begin
         b_v_ff   <= a_v_ff;
         b_sum_ff <= b_sum_in;
         b_neg_ff <= b_neg_in;
      end
   end

   // ---------------- divider: one quotient bit per stage ----------------
   logic [DW-1:0] d_rem_in [0:P][NC];
   logic [QW-1:0] d_quo_in [0:P][NC];
   logic [DW:0]   d_sh     [0:P][NC];

   logic          d_valid_ff [0:P];
   logic [DW-1:0] d_rem_ff   [0:P][NC];
   logic [QW-1:0] d_quo_ff   [0:P][NC];
   logic [DW-1:0] d_sum_ff   [0:P];
   logic [NC-1:0] d_neg_ff   [0:P];

   always_comb begin
      for (int k = 0; k < NC; k++) begin
         // integer part: one only when this term is the whole sum
         d_sh[0][k] = '0;
         if (DW'(b_v_ff[k]) >= b_sum_ff) begin
            d_rem_in[0][k] = DW'(b_v_ff[k]) - b_sum_ff;
            d_quo_in[0][k] = QW'(1);
         end else begin
            d_rem_in[0][k] = DW'(b_v_ff[k]);
            d_quo_in[0][k] = '0;
         end
      end
      for (int s = 1; s <= P; s++) begin
         for (int k = 0; k < NC; k++) begin
            d_sh[s][k] = {d_rem_ff[s-1][k], 1'b0};
            if (d_sh[s][k] >= (DW+1)'(d_sum_ff[s-1])) begin
               d_rem_in[s][k] = DW'(d_sh[s][k] - (DW+1)'(d_sum_ff[s-1]));
               d_quo_in[s][k] = {d_quo_ff[s-1][k][QW-2:0], 1'b1};
            end else begin
               d_rem_in[s][k] = DW'(d_sh[s][k]);
               d_quo_in[s][k] = {d_quo_ff[s-1][k][QW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= P; s++) d_valid_ff[s] <= 1'b0;
      end else if (adv) begin
         d_valid_ff[0] <= b_valid_ff;
         for (int s = 1; s <= P; s++) d_valid_ff[s] <= d_valid_ff[s-1];
      end
      if (adv) begin
         d_rem_ff <= d_rem_in;
         d_quo_ff <= d_quo_in;
         d_sum_ff[0] <= b_sum_ff;
         d_neg_ff[0] <= b_neg_ff;
         for (int s = 1; s <= P; s++) begin
            d_sum_ff[s] <= d_sum_ff[s-1];
            d_neg_ff[s] <= d_neg_ff[s-1];
         end
      end
   end

   // ---------------- square root: one root bit per stage ----------------
   logic [SW-1:0]  q_rem_prev [0:R-1][NC];
   logic [R-1:0]   q_root_prev [0:R-1][NC];
   logic [2*R-1:0] q_rad_prev [0:R-1][NC];
   logic [SW+1:0]  q_sh    [0:R-1][NC];
   logic [SW+1:0]  q_trial [0:R-1][NC];
   logic [SW-1:0]  q_rem_in  [0:R-1][NC];
   logic [R-1:0]   q_root_in [0:R-1][NC];

   logic           q_valid_ff [0:R-1];
   logic [SW-1:0]  q_rem_ff   [0:R-1][NC];
   logic [R-1:0]   q_root_ff  [0:R-1][NC];
   logic [2*R-1:0] q_rad_ff   [0:R-1][NC];
   logic [NC-1:0]  q_neg_ff   [0:R-1];

   always_comb begin
      for (int s = 0; s < R; s++) begin
         for (int k = 0; k < NC; k++) begin
            if (s == 0) begin
               q_rem_prev[s][k]  = '0;
               q_root_prev[s][k] = '0;
               q_rad_prev[s][k]  = (2*R)'(d_quo_ff[P][k]);
            end else begin
               q_rem_prev[s][k]  = q_rem_ff[s-1][k];
               q_root_prev[s][k] = q_root_ff[s-1][k];
               q_rad_prev[s][k]  = q_rad_ff[s-1][k];
            end
            q_sh[s][k]    = {q_rem_prev[s][k], q_rad_prev[s][k][2*(R-1-s) +: 2]};
            q_trial[s][k] = (SW+2)'({q_root_prev[s][k], 2'b01});
            if (q_sh[s][k] >= q_trial[s][k]) begin
               q_rem_in[s][k]  = SW'(q_sh[s][k] - q_trial[s][k]);
               q_root_in[s][k] = {q_root_prev[s][k][R-2:0], 1'b1};
            end else begin
               q_rem_in[s][k]  = SW'(q_sh[s][k]);
               q_root_in[s][k] = {q_root_prev[s][k][R-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < R; s++) q_valid_ff[s] <= 1'b0;
      end else if (adv) begin
         q_valid_ff[0] <= d_valid_ff[P];
         for (int s = 1; s < R; s++) q_valid_ff[s] <= q_valid_ff[s-1];
      end
      if (adv) begin
         q_rem_ff  <= q_rem_in;
         q_root_ff <= q_root_in;
         q_rad_ff  <= q_rad_prev;
         q_neg_ff[0] <= d_neg_ff[P];
         for (int s = 1; s < R; s++) q_neg_ff[s] <= q_neg_ff[s-1];
      end
   end

   // ---------------- output: round, saturate, apply sign ----------------
   logic [R:0]          o_rnd  [NC];
   logic [R-1:0]        o_mag  [NC];
   logic signed [FW-1:0] o_val [NC];
   rmq_pkg::rsp_type    rsp_data_in;
   rmq_pkg::rsp_type    rsp_data_ff;
   logic                rsp_valid_ff;

   always_comb begin
      for (int k = 0; k < NC; k++) begin
         o_rnd[k] = (R+1)'(q_root_ff[R-1][k]) + (R+1)'(1);
         o_mag[k] = o_rnd[k][R:1];
         if (o_mag[k] > R'(LIM)) o_mag[k] = R'(LIM);
         o_val[k] = q_neg_ff[R-1][k] ? -FW'(o_mag[k]) : FW'(o_mag[k]);
      end
      rsp_data_in.quat_w = o_val[rmq_pkg::COMP_W];
      rsp_data_in.quat_x = o_val[rmq_pkg::COMP_X];
      rsp_data_in.quat_y = o_val[rmq_pkg::COMP_Y];
      rsp_data_in.quat_z = o_val[rmq_pkg::COMP_Z];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= q_valid_ff[R-1];
      end
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
